>>> hw/rtl/sorted_priority_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Sorted priority queue core: assertion macros
// Shared assertion forms for the queue RTL. Each macro expects clk and rst_n
// in scope at the place of use.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Field widths, operation and status codes, and the command that the top
// level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned TOTAL_W = 5;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command seen by every cell in the cycle an item is accepted.
  typedef struct packed {
    logic                     enq;
    logic                     deq;
    logic signed [VALUE_W-1:0] data;
    logic        [PRIO_W-1:0]  prio;
  } spq_cmd_t;

endpackage

>>> hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain. On an insert it compares its priority with
// the new one, then keeps, takes the new item, or takes its left neighbor's
// entry. On a removal it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic                      clk,
  input  spq_cmd_t                  cmd,
  input  logic                      occupied,
  input  logic                      at_tail,
  input  logic                      left_gt,
  input  logic signed [VALUE_W-1:0] left_data,
  input  logic        [PRIO_W-1:0]  left_prio,
  input  logic signed [VALUE_W-1:0] right_data,
  input  logic        [PRIO_W-1:0]  right_prio,
  output logic signed [VALUE_W-1:0] cell_data,
  output logic        [PRIO_W-1:0]  cell_prio,
  output logic                      cell_gt
);

  logic signed [VALUE_W-1:0] data_r, data_nxt;
  logic        [PRIO_W-1:0]  prio_r, prio_nxt;

  // This entry is stored and must move behind the new item.
  assign cell_gt = occupied && (prio_r > cmd.prio);

  // Select the next content of the slot.
  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (cmd.enq) begin
      if (left_gt) begin
        data_nxt = left_data;
        prio_nxt = left_prio;
      end else if (cell_gt || at_tail) begin
        data_nxt = cmd.data;
        prio_nxt = cmd.prio;
      end
    end else if (cmd.deq) begin
      data_nxt = right_data;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign cell_data = data_r;
  assign cell_prio = prio_r;

endmodule

>>> hw/rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Bounded priority queue held as a chain of compare-and-shift cells, lowest
// priority number at the head; equal priorities leave in arrival order.
//
//   Channel  Ports                                  Handshake
//   input    in_opcode, in_item_value,              start high, busy low
//            in_item_priority
//   result   out_status, out_head_value,            out_strobe, one cycle
//            out_head_priority, out_entry_total
//   config   cfg_data                               cfg_we
//
// One item is accepted every clock; busy stays low, since every cell settles
// its insert or shift in its own register update, with no stall.
// The result appears in the cycle after the item is accepted, for one cycle.
// Reset empties the queue and sets the capacity to 16; the cells need no
// clearing pass, as slots beyond the entry count are never read.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_opcode,
  input  logic signed [VALUE_W-1:0] in_item_value,
  input  logic        [PRIO_W-1:0]  in_item_priority,
  output logic                      out_strobe,
  output logic [1:0]                out_status,
  output logic signed [VALUE_W-1:0] out_head_value,
  output logic        [PRIO_W-1:0]  out_head_priority,
  output logic [TOTAL_W-1:0]        out_entry_total,
  input  logic                      cfg_we,
  input  logic [CAP_W-1:0]          cfg_data
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = CNT_W + CAP_W;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;

  logic                      out_strobe_r;
  status_t                   out_status_r, status_nxt;
  logic signed [VALUE_W-1:0] out_head_value_r, head_value_nxt;
  logic        [PRIO_W-1:0]  out_head_priority_r, head_prio_nxt;
  logic [TOTAL_W-1:0]        out_entry_total_r;

  logic     accept;
  logic     full;
  logic     empty;
  spq_cmd_t cmd;

  logic signed [VALUE_W-1:0] cell_data [DEPTH];
  logic        [PRIO_W-1:0]  cell_prio [DEPTH];
  logic                      cell_gt   [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Full when the count reaches the capacity or the chain length.
  assign full  = (CMP_W'(count_r) >= CMP_W'(cap_r)) || (CMP_W'(count_r) >= CMP_W'(DEPTH));
  assign empty = (count_r == '0);

  // Command broadcast to the cells; dropped operations leave them alone.
  always_comb begin
    cmd.enq  = accept && (in_opcode == OP_ENQ) && !full;
    cmd.deq  = accept && (in_opcode == OP_DEQ) && !empty;
    cmd.data = in_item_value;
    cmd.prio = in_item_priority;
  end

  // The chain of cells, each wired to its two neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      left_gt;
    logic signed [VALUE_W-1:0] left_data;
    logic        [PRIO_W-1:0]  left_prio;
    logic signed [VALUE_W-1:0] right_data;
    logic        [PRIO_W-1:0]  right_prio;

    if (i == 0) begin : g_head
      assign left_gt   = 1'b0;
      assign left_data = '0;
      assign left_prio = '0;
    end else begin : g_mid
      assign left_gt   = cell_gt[i-1];
      assign left_data = cell_data[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = '0;
      assign right_prio = '0;
    end else begin : g_body
      assign right_data = cell_data[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (CNT_W'(i) < count_r),
      .at_tail    (CNT_W'(i) == count_r),
      .left_gt    (left_gt),
      .left_data  (left_data),
      .left_prio  (left_prio),
      .right_data (right_data),
      .right_prio (right_prio),
      .cell_data  (cell_data[i]),
      .cell_prio  (cell_prio[i]),
      .cell_gt    (cell_gt[i])
    );
  end

  // Next count and result fields.
  always_comb begin
    count_nxt      = count_r;
    status_nxt     = ST_DONE;
    head_value_nxt = '0;
    head_prio_nxt  = '0;
    if (in_opcode == OP_ENQ) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt      = count_r - CNT_W'(1);
        head_value_nxt = cell_data[0];
        head_prio_nxt  = cell_prio[0];
      end
    end
  end

  // Control state: entry count, capacity and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      cap_r        <= CAP_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      out_strobe_r <= accept;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r        <= status_nxt;
      out_head_value_r    <= head_value_nxt;
      out_head_priority_r <= head_prio_nxt;
      out_entry_total_r   <= TOTAL_W'(count_nxt);
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_head_value    = out_head_value_r;
  assign out_head_priority = out_head_priority_r;
  assign out_entry_total   = out_entry_total_r;

  // Every accepted item yields a result in the next cycle.
  `SPQ_ASSERT_NEXT(a_strobe_follows, accept, out_strobe_r, "result strobe missing after accept")
  // A successful insert grows the queue by exactly one entry.
  `SPQ_ASSERT_NEXT(a_enq_grows, cmd.enq, count_r == $past(count_r) + 1'b1, "insert did not grow count")
  // An empty report carries zero fields.
  `SPQ_ASSERT_SAME(a_empty_zero, out_strobe_r && (out_status_r == ST_EMPTY), (out_entry_total_r == '0) && (out_head_value_r == '0) && (out_head_priority_r == '0), "empty result has nonzero fields")
  // The count never exceeds the chain length.
  `SPQ_ASSERT_SAME(a_count_bound, 1'b1, CMP_W'(count_r) <= CMP_W'(DEPTH), "entry count beyond chain length")
  // The two front entries stay in priority order.
  `SPQ_ASSERT_SAME(a_head_sorted, count_r >= CNT_W'(2), cell_prio[0] <= cell_prio[1], "head entries out of order")

endmodule

>>> tb/sv/sorted_priority_queue_core_tb.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Drives enqueue and dequeue items with bursty gaps, mirrors the queue in a
// behavioral copy, and compares every result strobe field by field. Covers
// ties, field extremes, empty and full queues, and capacity changes that
// include zero, values above the depth, and values below the stored count.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned QDEPTH     = 16;
  localparam int unsigned LATENCY    = 1;
  localparam int unsigned IDLE_LIMIT = 1000;

  // One predicted result of the queue.
  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] head_value;
    logic        [PRIO_W-1:0]  head_priority;
    logic        [TOTAL_W-1:0] entry_total;
  } queue_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_opcode;
  logic signed [VALUE_W-1:0] in_item_value;
  logic        [PRIO_W-1:0]  in_item_priority;
  logic                      out_strobe;
  logic [1:0]                out_status;
  logic signed [VALUE_W-1:0] out_head_value;
  logic        [PRIO_W-1:0]  out_head_priority;
  logic [TOTAL_W-1:0]        out_entry_total;
  logic                      cfg_we;
  logic [CAP_W-1:0]          cfg_data;

  // Mirror of the queue contents and the capacity register.
  logic signed [VALUE_W-1:0] mirror_value [QDEPTH];
  logic        [PRIO_W-1:0]  mirror_prio  [QDEPTH];
  int unsigned               mirror_count;
  logic        [CAP_W-1:0]   mirror_capacity;

  queue_result_t pending_results [$];

  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned full_drops;
  int unsigned empty_pops;
  int unsigned depth_hits;
  int unsigned capacity_writes;

  sorted_priority_queue_core #(
    .DEPTH(QDEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_head_value   (out_head_value),
    .out_head_priority(out_head_priority),
    .out_entry_total  (out_entry_total),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data)
  );

  // Free-running 2 ns clock.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Apply one item to the mirror and return the result it should produce.
  function automatic queue_result_t apply_queue_op(input logic op,
                                                   input logic signed [VALUE_W-1:0] val,
                                                   input logic [PRIO_W-1:0] prio);
    queue_result_t r;
    int unsigned   lim;
    int unsigned   slot;
    r.status        = ST_DONE;
    r.head_value    = '0;
    r.head_priority = '0;
    if (op == OP_ENQ) begin
      lim = (mirror_capacity > QDEPTH) ? QDEPTH : int'(mirror_capacity);
      if (mirror_count >= lim) begin
        r.status = ST_FULL;
      end else begin
        // Walk back past every entry with a strictly larger priority number.
        slot = mirror_count;
        while (slot > 0 && mirror_prio[slot-1] > prio) begin
          mirror_value[slot] = mirror_value[slot-1];
          mirror_prio[slot]  = mirror_prio[slot-1];
          slot--;
        end
        mirror_value[slot] = val;
        mirror_prio[slot]  = prio;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.head_value    = mirror_value[0];
        r.head_priority = mirror_prio[0];
        for (int k = 0; k + 1 < mirror_count; k++) begin
          mirror_value[k] = mirror_value[k+1];
          mirror_prio[k]  = mirror_prio[k+1];
        end
        mirror_count--;
      end
    end
    r.entry_total = mirror_count[TOTAL_W-1:0];
    return r;
  endfunction

  // Predict on every accepted item, then check any result in the same edge.
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      mirror_count    = 0;
      mirror_capacity = CAP_RESET;
    end else begin
      if (cfg_we) begin
        mirror_capacity = cfg_data;
      end
      if (start && !busy) begin
        pending_results.push_back(apply_queue_op(in_opcode, in_item_value, in_item_priority));
      end
      if (out_strobe) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with no item pending, status %0d total %0d",
                   $time, out_status, out_entry_total);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (want.status == ST_FULL) full_drops++;
          if (want.status == ST_EMPTY) empty_pops++;
          if (want.entry_total == QDEPTH) depth_hits++;
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_status);
            error_count++;
          end
          if (out_head_value !== want.head_value) begin
            $display("%0t: head_value mismatch, expected %0d, got %0d",
                     $time, want.head_value, out_head_value);
            error_count++;
          end
          if (out_head_priority !== want.head_priority) begin
            $display("%0t: head_priority mismatch, expected %0d, got %0d",
                     $time, want.head_priority, out_head_priority);
            error_count++;
          end
          if (out_entry_total !== want.entry_total) begin
            $display("%0t: entry_total mismatch, expected %0d, got %0d",
                     $time, want.entry_total, out_entry_total);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no activity for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL sorted_priority_queue_core");
      $finish;
    end
  end

  // Send one item, opening a new burst, often after a random gap, when the last ends.
  task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] val,
                           input logic [PRIO_W-1:0] prio);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start            <= 1'b1;
    in_opcode        <= op;
    in_item_value    <= val;
    in_item_priority <= prio;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // A dequeue carries random payload, which the block must ignore.
  task automatic send_pop();
    send_item(OP_DEQ, $urandom, PRIO_W'($urandom_range(0, 255)));
  endtask

  // Let every pending result arrive before touching the register.
  task automatic settle_queue();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 1) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    settle_queue();
    cfg_we   <= 1'b1;
    cfg_data <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    capacity_writes++;
  endtask

  // A fresh queue reports empty on a dequeue.
  task automatic test_empty_after_reset();
    send_pop();
  endtask

  // Field extremes and ties at both ends leave in priority, then arrival, order.
  task automatic test_order_and_extremes();
    send_item(OP_ENQ, 32'sh7fffffff, 8'd255);
    send_item(OP_ENQ, 32'sh80000000, 8'd0);
    send_item(OP_ENQ, 32'sd0,        8'd128);
    send_item(OP_ENQ, -32'sd1,       8'd128);
    send_item(OP_ENQ, 32'sd5,        8'd0);
    send_item(OP_ENQ, 32'sh55555555, 8'd255);
    repeat (7) send_pop();
  endtask

  // Lowering the capacity below the stored count blocks enqueues but not pops.
  task automatic test_capacity_below_count();
    send_item(OP_ENQ, 32'sd11, 8'd9);
    send_item(OP_ENQ, 32'sd22, 8'd3);
    send_item(OP_ENQ, 32'sd33, 8'd9);
    write_capacity(5'd2);
    send_item(OP_ENQ, 32'sd44, 8'd1);
    send_pop();
    send_item(OP_ENQ, 32'sd55, 8'd1);
    send_pop();
    send_item(OP_ENQ, 32'sd66, 8'd9);
    send_pop();
    send_pop();
  endtask

  // A capacity of zero refuses every enqueue.
  task automatic test_capacity_zero();
    write_capacity(5'd0);
    send_item(OP_ENQ, 32'sd77, 8'd7);
    send_pop();
  endtask

  // Random phases: each sets a capacity, fills for a while, then drains.
  task automatic test_random_phases();
    logic [CAP_W-1:0]          caps [8];
    logic signed [VALUE_W-1:0] val;
    logic        [PRIO_W-1:0]  prio;
    int unsigned               fill_pct;
    int unsigned               drain_pct;
    int unsigned               pct;
    caps = '{5'd31, 5'd1, 5'd16, 5'd17, 5'd5, 5'd0, 5'd3, 5'd0};
    caps[5] = CAP_W'($urandom_range(1, 16));
    caps[7] = CAP_W'($urandom_range(0, 31));
    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(caps[ph]);
      fill_pct  = $urandom_range(65, 90);
      drain_pct = $urandom_range(20, 50);
      for (int i = 0; i < 65; i++) begin
        pct = (i < 32) ? fill_pct : drain_pct;
        case ($urandom_range(0, 7))
          0:       val = 32'sh80000000;
          1:       val = 32'sh7fffffff;
          default: val = $urandom;
        endcase
        // Half the priorities come from a narrow set to force ties.
        prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 255))
                                    : PRIO_W'($urandom_range(0, 3) * 85);
        if ($urandom_range(0, 99) < pct) begin
          send_item(OP_ENQ, val, prio);
        end else begin
          send_item(OP_DEQ, val, prio);
        end
      end
    end
  endtask

  // Wait for the last results, summarize and give the verdict.
  task automatic finish_run();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    $display("Sent %0d items, checked %0d results over %0d capacity settings.",
             items_sent, results_seen, capacity_writes + 1);
    $display("Dropped on full: %0d, popped while empty: %0d, filled to depth: %0d.",
             full_drops, empty_pops, depth_hits);
    if (error_count == 0) begin
      $display("PASS sorted_priority_queue_core");
    end else begin
      $display("FAIL sorted_priority_queue_core");
    end
    $finish;
  endtask

  // Reset once, then run the tests in turn.
  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_opcode        = OP_ENQ;
    in_item_value    = '0;
    in_item_priority = '0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    burst_left       = 0;
    error_count      = 0;
    items_sent       = 0;
    results_seen     = 0;
    full_drops       = 0;
    empty_pops       = 0;
    depth_hits       = 0;
    capacity_writes  = 0;
    mirror_count     = 0;
    mirror_capacity  = CAP_RESET;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_after_reset();
    test_order_and_extremes();
    test_capacity_below_count();
    test_capacity_zero();
    test_random_phases();
    finish_run();
  end

endmodule
